[rtl/core/u8d_pkg.sv]
// shared types and byte constants for the utf-8 byte stream decoder
// no dependencies; used by the interfaces, u8d_step and the top level

package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned CntW  = 2;

  localparam logic [ByteW-1:0] ByteZero    = 8'h00;
  localparam logic [ByteW-1:0] ByteAsciiHi = 8'h7F;
  localparam logic [ByteW-1:0] ByteContHi  = 8'hBF;
  localparam logic [ByteW-1:0] ByteLead2   = 8'hC0;
  localparam logic [ByteW-1:0] ByteLead3   = 8'hE0;
  localparam logic [ByteW-1:0] ByteLead4   = 8'hF0;
  localparam logic [ByteW-1:0] ByteBad     = 8'hF8;

  localparam logic [ByteW-1:0] MaskLead2 = 8'h1F;
  localparam logic [ByteW-1:0] MaskLead3 = 8'h0F;
  localparam logic [ByteW-1:0] MaskLead4 = 8'h07;
  localparam logic [ByteW-1:0] MaskCont  = 8'h3F;

  localparam logic [CntW-1:0] NeedOne   = 2'd1;
  localparam logic [CntW-1:0] NeedTwo   = 2'd2;
  localparam logic [CntW-1:0] NeedThree = 2'd3;

  typedef struct packed {
    logic            in_sequence;
    logic [CntW-1:0] needed_count;
    logic [CntW-1:0] seen_count;
    logic [CpW-1:0]  accumulator;
  } dec_state_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           char_ready;
  } dec_result_t;

  localparam dec_state_t StateReset = '{
    in_sequence:  1'b0,
    needed_count: '0,
    seen_count:   '0,
    accumulator:  '0
  };

endpackage

[rtl/core/u8d_ifs.sv]
// valid/ready channel interfaces for the byte input and the character output
// depends on u8d_pkg for field widths

interface u8d_byte_if;
  import u8d_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface u8d_char_if;
  import u8d_pkg::*;

  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           char_ready;

  modport source (output valid, output code_point, output char_ready, input ready);
  modport sink (input valid, input code_point, input char_ready, output ready);
endinterface

[rtl/core/u8d_step.sv]
// per-byte decode step: next decoder state and result from current state and byte
// depends on u8d_pkg

module u8d_step (
  input  u8d_pkg::dec_state_t  state,
  input  logic [7:0]           byte_in,
  output u8d_pkg::dec_state_t  state_next,
  output u8d_pkg::dec_result_t result
);
  import u8d_pkg::*;

  logic [CntW-1:0] seen_inc;
  logic [CpW-1:0]  acc_shift;
  logic [ByteW-1:0] cont_bits;

  assign seen_inc  = state.seen_count + CntW'(1);
  assign cont_bits = byte_in & MaskCont;
  assign acc_shift = {state.accumulator[CpW-7:0], cont_bits[5:0]};

  always_comb begin
    state_next = state;
    result     = '0;
    if (byte_in == ByteZero) begin
      state_next = StateReset;
    end else if (!state.in_sequence) begin
      if (byte_in >= ByteBad) begin
        state_next = state;
      end else if (byte_in >= ByteLead4) begin
        state_next.accumulator  = CpW'(byte_in & MaskLead4);
        state_next.needed_count = NeedThree;
        state_next.seen_count   = '0;
        state_next.in_sequence  = 1'b1;
      end else if (byte_in >= ByteLead3) begin
        state_next.accumulator  = CpW'(byte_in & MaskLead3);
        state_next.needed_count = NeedTwo;
        state_next.seen_count   = '0;
        state_next.in_sequence  = 1'b1;
      end else if (byte_in >= ByteLead2) begin
        state_next.accumulator  = CpW'(byte_in & MaskLead2);
        state_next.needed_count = NeedOne;
        state_next.seen_count   = '0;
        state_next.in_sequence  = 1'b1;
      end else if (byte_in <= ByteAsciiHi) begin
        result.code_point = CpW'(byte_in);
        result.char_ready = 1'b1;
      end
    end else if (byte_in > ByteContHi) begin
      state_next.in_sequence  = 1'b0;
      state_next.needed_count = '0;
      state_next.seen_count   = '0;
    end else begin
      state_next.accumulator = acc_shift;
      state_next.seen_count  = seen_inc;
      if (seen_inc == state.needed_count) begin
        result.code_point       = acc_shift;
        result.char_ready       = 1'b1;
        state_next.in_sequence  = 1'b0;
        state_next.needed_count = '0;
        state_next.seen_count   = '0;
      end
    end
  end

endmodule

[rtl/core/utf8_byte_stream_decoder_unit.sv]
// top level of the utf-8 byte stream decoder: state register and output register
// depends on u8d_pkg, u8d_ifs and u8d_step

// Takes one byte per clock while the output is not stalled and returns exactly one
// result per byte: the decoded code point with char_ready high on the byte that
// completes a character, otherwise zero. The result and the decoder state are both
// registered when the byte is accepted. The only stall is the output register: while
// it holds an untaken result, in_chan.ready follows out_chan.ready. A zero byte clears
// the decoder; there are no overlong or range checks.
module utf8_byte_stream_decoder_unit (
  input logic        clk,
  input logic        rst,
  u8d_byte_if.sink   in_chan,
  u8d_char_if.source out_chan
);
  import u8d_pkg::*;

  dec_state_t  state;
  dec_state_t  state_next;
  dec_result_t result;
  dec_result_t out_reg;
  logic        out_valid;
  logic        accept;

  assign in_chan.ready = !out_valid || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  u8d_step u_step (
    .state      (state),
    .byte_in    (in_chan.byte_in),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StateReset;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign out_chan.valid      = out_valid;
  assign out_chan.code_point = out_reg.code_point;
  assign out_chan.char_ready = out_reg.char_ready;

`ifndef SYNTHESIS
  a_seq_count: assert property (@(posedge clk) disable iff (rst)
    state.in_sequence == (state.needed_count != '0))
    else $error("sequence flag and needed count disagree");

  a_seen_below_needed: assert property (@(posedge clk) disable iff (rst)
    state.in_sequence |-> (state.seen_count < state.needed_count))
    else $error("seen count reached needed count inside a sequence");

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_chan.byte_in == ByteZero) |=> (state == StateReset))
    else $error("zero byte did not clear the decoder");

  a_idle_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reg.char_ready) |-> (out_reg.code_point == '0))
    else $error("nonzero code point without a completed character");
`endif

endmodule

[verif/tb_utf8_byte_stream_decoder_unit.sv]
// self-checking testbench for utf8_byte_stream_decoder_unit: directed and random byte streams
// depends on u8d_pkg, u8d_ifs and the decoder rtl; scoreboard predicts one result per byte
`timescale 1ns / 1ps

module tb_utf8_byte_stream_decoder_unit;
  import u8d_pkg::*;

  class char_scoreboard;
    logic                in_seq;
    logic [CntW-1:0]     need;
    logic [CntW-1:0]     seen;
    logic [CpW-1:0]      acc;
    dec_result_t         expected_chars[$];
    int unsigned         mismatches;

    function new();
      in_seq = 1'b0;
      need = '0;
      seen = '0;
      acc = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    function void go_idle();
      in_seq = 1'b0;
      need = '0;
      seen = '0;
    endfunction

    function void note_byte(input logic [ByteW-1:0] b);
      dec_result_t r;
      r = '0;
      if (b == ByteZero) begin
        go_idle();
        acc = '0;
      end else if (!in_seq) begin
        if (b >= ByteBad) begin
          // ignored
        end else if (b >= ByteLead4) begin
          acc = CpW'(b & MaskLead4);
          need = NeedThree;
          seen = '0;
          in_seq = 1'b1;
        end else if (b >= ByteLead3) begin
          acc = CpW'(b & MaskLead3);
          need = NeedTwo;
          seen = '0;
          in_seq = 1'b1;
        end else if (b >= ByteLead2) begin
          acc = CpW'(b & MaskLead2);
          need = NeedOne;
          seen = '0;
          in_seq = 1'b1;
        end else if (b <= ByteAsciiHi) begin
          r.code_point = CpW'(b);
          r.char_ready = 1'b1;
        end
      end else if (b > ByteContHi) begin
        go_idle();
      end else begin
        acc = {acc[CpW-7:0], b[5:0]};
        seen = seen + 1'b1;
        if (seen == need) begin
          r.code_point = acc;
          r.char_ready = 1'b1;
          go_idle();
        end
      end
      expected_chars.push_back(r);
    endfunction

    function void check_char(input logic [CpW-1:0] cp, input logic rdy);
      dec_result_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual code_point=%h char_ready=%b",
                 $time, cp, rdy);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (cp !== want.code_point) begin
        $display("%0t: code_point expected %h actual %h", $time, want.code_point, cp);
        mismatches++;
      end
      if (rdy !== want.char_ready) begin
        $display("%0t: char_ready expected %b actual %b", $time, want.char_ready, rdy);
        mismatches++;
      end
    endfunction
  endclass

  localparam int unsigned TotalBytes = 1850;

  logic clk = 1'b0;
  logic rst = 1'b1;

  u8d_byte_if in_if ();
  u8d_char_if out_if ();

  utf8_byte_stream_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  char_scoreboard board;
  int unsigned    gap_pct;
  int unsigned    bytes_sent;

  logic [ByteW-1:0] opening [25] = '{
    8'h00, 8'h01, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
    8'hC0, 8'h80,
    8'hF7, 8'hBF, 8'hBF, 8'hBF,
    8'hE2, 8'h82, 8'hAC,
    8'hC3, 8'hFF,
    8'hC3, 8'h41,
    8'hF0, 8'h9F, 8'h00,
    8'hE0, 8'hC0
  };

  int unsigned phase_gap [5] = '{25, 0, 50, 10, 35};

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.byte_in <= b;
    do @(posedge clk); while (!in_if.ready);
    board.note_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [ByteW-1:0] cont_byte();
    if ($urandom_range(0, 11) == 0)
      return ByteW'($urandom_range(1, ByteAsciiHi));
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  task automatic send_sequence(input int unsigned n, input int unsigned upto);
    logic [ByteW-1:0] lead;
    case (n)
      1: begin
        lead = ByteW'($urandom_range(ByteLead2, ByteLead3 - 1));
      end
      2: begin
        lead = ByteW'($urandom_range(ByteLead3, ByteLead4 - 1));
      end
      default: begin
        lead = ByteW'($urandom_range(ByteLead4, ByteBad - 1));
      end
    endcase
    send_byte(lead);
    for (int unsigned i = 0; i < upto; i++) send_byte(cont_byte());
  endtask

  task automatic send_random_unit();
    int unsigned k;
    int unsigned n;
    k = $urandom_range(0, 99);
    n = $urandom_range(1, 3);
    if (k < 25) begin
      send_byte(ByteW'($urandom_range(1, ByteAsciiHi)));
    end else if (k < 85) begin
      send_sequence(n, n);
    end else if (k < 91) begin
      send_sequence(n, $urandom_range(0, n - 1));
      send_byte(ByteW'($urandom_range(ByteLead2, 8'hFF)));
    end else if (k < 94) begin
      send_byte(ByteW'($urandom_range(8'h80, ByteContHi)));
    end else if (k < 96) begin
      send_byte(ByteW'($urandom_range(ByteBad, 8'hFF)));
    end else if (k < 97) begin
      send_byte(ByteZero);
    end else begin
      send_sequence(n, $urandom_range(0, n - 1));
      send_byte(ByteZero);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready)
      board.check_char(out_if.code_point, out_if.char_ready);
  end

  initial begin
    do @(posedge clk); while (rst);
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    board = new();
    gap_pct = 20;
    bytes_sent = 0;
    in_if.valid = 1'b0;
    in_if.byte_in = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_byte(opening[i]);

    for (int p = 0; p < 5; p++) begin
      gap_pct = phase_gap[p];
      while (bytes_sent < 25 + 300 * (p + 1)) send_random_unit();
    end
    gap_pct = 0;
    while (bytes_sent < TotalBytes) send_random_unit();

    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
